// ----- sv/b64e_pkg.sv -----
// Shared types, character constants and the sextet-to-ASCII mapping
// for the Base64 stream encoder. No dependencies.
package b64e_pkg;

   localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
   localparam logic [7:0] CharLowerA = 8'h61;  // 'a'
   localparam logic [7:0] CharZero   = 8'h30;  // '0'
   localparam logic [7:0] CharPlus   = 8'h2B;  // '+'
   localparam logic [7:0] CharSlash  = 8'h2F;  // '/'
   localparam logic [7:0] CharMinus  = 8'h2D;  // '-'
   localparam logic [7:0] CharUnder  = 8'h5F;  // '_'
   localparam logic [7:0] CharPad    = 8'h3D;  // '='

   localparam logic [5:0] SextetLowerStart = 6'd26;
   localparam logic [5:0] SextetDigitStart = 6'd52;
   localparam logic [5:0] SextetPlus       = 6'd62;
   localparam logic [5:0] SextetSlash      = 6'd63;

   localparam int unsigned SymsPerJob = 4;

   // One output symbol: a padding mark or a 6-bit alphabet index
   typedef struct packed {
      logic       pad;
      logic [5:0] value;
   } sym_type;

   // Work for the back end produced by one input byte
   typedef struct packed {
      sym_type [SymsPerJob-1:0] syms;
      logic [1:0]               last_idx;  // index of the final symbol of this job
      logic                     eom;       // final symbol closes the message
   } job_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
      logic [7:0] c;
      if (v < SextetLowerStart) begin
         c = CharUpperA + {2'b00, v};
      end else if (v < SextetDigitStart) begin
         c = CharLowerA + {2'b00, v - SextetLowerStart};
      end else if (v < SextetPlus) begin
         c = CharZero + {2'b00, v - SextetDigitStart};
      end else if (v == SextetPlus) begin
         c = url ? CharMinus : CharPlus;
      end else begin
         c = url ? CharUnder : CharSlash;
      end
      return c;
   endfunction

endpackage

// ----- sv/b64e_if.sv -----
// Valid/ready channel interfaces for request bytes, response characters
// and the configuration write. Depends on nothing.
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;
   modport source (output valid, output out_char, output last_char, input ready);
   modport sink (input valid, input out_char, input last_char, output ready);
endinterface

interface b64e_csr_if;
   logic valid;
   logic ready;
   logic url_alphabet;
   modport source (output valid, output url_alphabet, input ready);
   modport sink (input valid, input url_alphabet, output ready);
endinterface

// ----- sv/base64_stream_encoder.sv -----
// Base64 stream encoder top level: configuration register, front end, job queue and back end.
// Depends on b64e_pkg, the channel interfaces and the b64e_* submodules.
//
// One raw byte per request transfer (last_byte marks the end of a message) becomes one to four
// ASCII characters on the response channel, one character per cycle while the response channel
// is ready, from a registered output. A byte at group position 0 or 1 gives one character, at
// position 2 two; a flagged last byte at position 0 gives four (two of them '='), at position 1
// three (one '='). The output register sets the rate, so a long message gives four characters
// for every three bytes. A queue of QueueDepth jobs lets bytes be taken while characters of
// earlier bytes are still waiting; the first character of a byte passes through the queue and
// then the output register before it is visible. url_alphabet selects '-' and '_' instead of
// '+' and '/'; write it only once all characters have gone. A write in the middle of a message
// applies to every character loaded into the output register after it, queued bytes included.
module base64_stream_encoder #(
   parameter int unsigned QueueDepth = 2
) (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_if,
   b64e_rsp_if.source rsp_if,
   b64e_csr_if.sink   csr_if
);

   logic url_alphabet_ff;
   logic push, pop, full, empty;
   b64e_pkg::job_type push_job, head;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_alphabet_ff <= 1'b0;
      end else if (csr_if.valid) begin
         url_alphabet_ff <= csr_if.url_alphabet;
      end
   end

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (full),
      .push_valid (push),
      .push_job   (push_job)
   );

   b64e_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .url_alphabet (url_alphabet_ff),
      .head         (head),
      .empty        (empty),
      .pop          (pop),
      .rsp_if       (rsp_if)
   );

endmodule

// ----- sv/b64e_front.sv -----
// Front end: accepts raw bytes, tracks group position and leftover bits,
// and builds one symbol job per byte. Uses b64e_pkg and b64e_req_if.
module b64e_front (
   input  logic              clock,
   input  logic              reset,
   b64e_req_if.sink          req_if,
   input  logic              queue_full,
   output logic              push_valid,
   output b64e_pkg::job_type push_job
);

   logic [1:0] pos_ff, pos_in;
   logic [3:0] carry_ff, carry_in;
   logic       take;
   b64e_pkg::job_type job;

   assign req_if.ready = !queue_full;
   assign take         = req_if.valid && !queue_full;
   assign push_valid   = take;
   assign push_job     = job;

   always_comb begin
      logic [7:0] b;
      b        = req_if.data_byte;
      job      = '0;
      job.eom  = req_if.last_byte;
      pos_in   = pos_ff;
      carry_in = carry_ff;
      unique case (pos_ff)
         2'd1: begin
            job.syms[0].value = {carry_ff[1:0], b[7:4]};
            if (req_if.last_byte) begin
               job.syms[1].value = {b[3:0], 2'b00};
               job.syms[2].pad   = 1'b1;
               job.last_idx      = 2'd2;
               pos_in            = 2'd0;
               carry_in          = 4'd0;
            end else begin
               job.last_idx = 2'd0;
               pos_in       = 2'd2;
               carry_in     = b[3:0];
            end
         end
         2'd2: begin
            job.syms[0].value = {carry_ff, b[7:6]};
            job.syms[1].value = b[5:0];
            job.last_idx      = 2'd1;
            pos_in            = 2'd0;
            carry_in          = 4'd0;
         end
         default: begin
            // start of group; the unused code behaves the same
            job.syms[0].value = b[7:2];
            if (req_if.last_byte) begin
               job.syms[1].value = {b[1:0], 4'b0000};
               job.syms[2].pad   = 1'b1;
               job.syms[3].pad   = 1'b1;
               job.last_idx      = 2'd3;
               pos_in            = 2'd0;
               carry_in          = 4'd0;
            end else begin
               job.last_idx = 2'd0;
               pos_in       = 2'd1;
               carry_in     = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         carry_ff <= 4'd0;
      end else if (take) begin
         pos_ff   <= pos_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// ----- sv/b64e_queue.sv -----
// Small job queue that decouples the front end from the character output.
// Uses b64e_pkg for the job type.
module b64e_queue #(
   parameter int unsigned Depth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64e_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output b64e_pkg::job_type head,
   output logic              empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   b64e_pkg::job_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full  = (count_ff == FullCnt);
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- sv/b64e_back.sv -----
// Back end: walks the symbols of the head job, maps each to ASCII and
// holds it in the output register. Uses b64e_pkg and b64e_rsp_if.
module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              url_alphabet,
   input  b64e_pkg::job_type head,
   input  logic              empty,
   output logic              pop,
   b64e_rsp_if.source        rsp_if
);

   logic [1:0] idx_ff;
   logic       rsp_valid_ff;
   logic [7:0] char_ff, char_in;
   logic       last_ff;
   logic       load;
   logic       final_sym;
   b64e_pkg::sym_type sym;

   assign load      = !empty && (!rsp_valid_ff || rsp_if.ready);
   assign sym       = head.syms[idx_ff];
   assign final_sym = (idx_ff == head.last_idx);
   assign pop       = load && final_sym;
   assign char_in   = sym.pad ? b64e_pkg::CharPad
                              : b64e_pkg::sextet_char(sym.value, url_alphabet);

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_char  = char_ff;
   assign rsp_if.last_char = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= final_sym ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_if.ready) begin
            // drop the transferred character
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= head.eom && final_sym;
      end
   end

endmodule
